### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dsph_pkg.sv
`timescale 1ns / 1ps

package dsph_pkg;

	localparam int STAGE_COUNT = 4;
	localparam int DELAY_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int STAGE_W     = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
	localparam int BASE_W      = 9;
	localparam int GAIN_W      = 16;
	localparam int SMP_W       = 16;
	localparam int ACC_W       = 32;
	localparam int PROD_W      = ACC_W + GAIN_W;
	localparam int FRAC_W      = 8;
	localparam int FB_SHIFT    = 14;
	localparam int OUT_SHIFT   = 4;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int DLY_W       = (ADDR_W > BASE_W + STAGE_W) ? ADDR_W : BASE_W + STAGE_W;
	localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(48);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE        = 2'd0,
		REG_BASE_DELAY    = 2'd1,
		REG_FEEDBACK_GAIN = 2'd2
	} dsph_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAIN,
		ST_MULT,
		ST_FIN,
		ST_DONE
	} dsph_state_t;

	typedef logic signed [ACC_W-1:0] dsph_acc_t;

	typedef struct packed {
		logic              vld;
		logic [ACC_W-1:0]  wet;
	} dsph_link_t;

	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] wp;
		logic              wrapped;
		logic [BASE_W-1:0] base;
	} dsph_ctl_t;

	function automatic dsph_acc_t sat_acc(input logic [ACC_W:0] v);
		dsph_acc_t r;
		if (v[ACC_W] != v[ACC_W-1]) begin
			r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = v[ACC_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/dsph_cell.sv
`timescale 1ns / 1ps

module dsph_cell import dsph_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dsph_ctl_t          ctl,
	input  logic [STAGE_W-1:0] idx,
	input  dsph_link_t         link_in,
	output dsph_link_t         link_out
);

	dsph_acc_t          mem [DELAY_DEPTH];
	dsph_acc_t          rdata_q;
	logic               rok_q;
	logic               vld_q;
	dsph_acc_t          wet_q;
	logic [DLY_W-1:0]   dly;
	logic [ADDR_W-1:0]  rd_addr;
	logic               rd_ok;
	dsph_acc_t          b_val;
	dsph_acc_t          wet_in;
	dsph_acc_t          diff;
	dsph_acc_t          sum;

	assign dly     = DLY_W'(ctl.base) + DLY_W'(idx) * DLY_W'(ctl.base >> 1);
	assign rd_addr = ctl.wp - dly[ADDR_W-1:0];
	// Entries not yet written since reset read as zero.
	assign rd_ok   = ctl.wrapped || (rd_addr < ctl.wp);
	assign b_val   = rok_q ? rdata_q : '0;
	assign wet_in  = link_in.wet;
	assign diff    = sat_acc({b_val[ACC_W-1], b_val} - {wet_in[ACC_W-1], wet_in});
	assign sum     = sat_acc({wet_in[ACC_W-1], wet_in} + {b_val[ACC_W-1], b_val});

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rdata_q <= mem[rd_addr];
		end
		if (link_in.vld) begin
			mem[ctl.wp] <= sum;
			wet_q       <= diff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rok_q <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				rok_q <= rd_ok;
			end
			vld_q <= link_in.vld;
		end
	end

	assign link_out = '{vld: vld_q, wet: wet_q};

endmodule

### rtl/delay_stage_phaser.sv
`timescale 1ns / 1ps

// Phaser built from a row of all-pass delay cells, one cell and one 1024-word ring per stage.
// With the effect enabled a word goes through these steps from acceptance until the block
// can accept again: the wet value walks the cell row one cell per clock, the chain output
// is latched, the feedback multiply runs, saturation and output scaling follow, the result
// is handed to the output register once that register is free, and the block returns to
// the idle state in which the next word is taken. Bypassed words go straight to the hand-off.
// A finished word waits in the output register while the next word is taken in. The rings
// need no clearing pass after reset: a wrap flag on the shared write pointer makes slots
// never written since reset read as zero, so the block accepts words right after reset.
module delay_stage_phaser import dsph_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [SMP_W-1:0] sample_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SMP_W-1:0] sample_out
);

	dsph_state_t               state_q;
	dsph_state_t               state_d;
	logic                      enable_q;
	logic [BASE_W-1:0]         base_q;
	logic signed [GAIN_W-1:0]  gain_q;
	logic [ADDR_W-1:0]         wp_q;
	logic                      wrapped_q;
	dsph_acc_t                 fb_q;
	logic                      go_q;
	logic signed [SMP_W-1:0]   x_q;
	dsph_acc_t                 wet0_q;
	dsph_acc_t                 wetf_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [SMP_W-1:0]   res_q;
	logic                      out_valid_q;
	logic signed [SMP_W-1:0]   out_q;

	logic                      accept;
	logic                      start;
	logic                      chain_done;
	logic                      fin;
	logic                      out_load;
	dsph_ctl_t                 ctl;
	dsph_link_t                link [STAGE_COUNT+1];

	dsph_acc_t                 in256;
	dsph_acc_t                 x256;
	dsph_acc_t                 wet0;
	logic signed [PROD_W-1:0]  prod_bias;
	logic signed [PROD_W-1:0]  fb_div;
	dsph_acc_t                 fb_sat;
	dsph_acc_t                 mix;
	dsph_acc_t                 mix_bias;
	dsph_acc_t                 whole_w;
	logic signed [SMP_W-1:0]   whole16;
	logic signed [SMP_W-1:0]   shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		chain_done = 1'b0;
		fin        = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = enable_q ? ST_CHAIN : ST_DONE;
				end
			end
			ST_CHAIN: begin
				if (link[STAGE_COUNT].vld) begin
					chain_done = 1'b1;
					state_d    = ST_MULT;
				end
			end
			ST_MULT: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				fin     = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;
	assign start  = accept && enable_q;

	assign in256 = {{(ACC_W-SMP_W-FRAC_W){sample_in[SMP_W-1]}}, sample_in, FRAC_W'(0)};
	assign x256  = {{(ACC_W-SMP_W-FRAC_W){x_q[SMP_W-1]}}, x_q, FRAC_W'(0)};
	assign wet0  = sat_acc({fb_q[ACC_W-1], fb_q} + {in256[ACC_W-1], in256});

	assign ctl     = '{start: start, wp: wp_q, wrapped: wrapped_q, base: base_q};
	assign link[0] = '{vld: go_q, wet: wet0_q};

	for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_cell
		dsph_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.idx      (STAGE_W'(g)),
			.link_in  (link[g]),
			.link_out (link[g+1])
		);
	end

	// Division by powers of two truncates toward zero.
	assign prod_bias = prod_q[PROD_W-1] ? PROD_W'((1 << FB_SHIFT) - 1) : '0;
	assign fb_div    = (prod_q + prod_bias) >>> FB_SHIFT;
	always_comb begin
		if (&fb_div[PROD_W-1:ACC_W-1] || ~|fb_div[PROD_W-1:ACC_W-1]) begin
			fb_sat = fb_div[ACC_W-1:0];
		end else begin
			fb_sat = fb_div[PROD_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	assign mix      = sat_acc({x256[ACC_W-1], x256} + {wetf_q[ACC_W-1], wetf_q});
	assign mix_bias = mix[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : '0;
	assign whole_w  = (mix + mix_bias) >>> FRAC_W;
	always_comb begin
		if (&whole_w[ACC_W-1:SMP_W-1] || ~|whole_w[ACC_W-1:SMP_W-1]) begin
			whole16 = whole_w[SMP_W-1:0];
		end else begin
			whole16 = whole_w[ACC_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
		end
	end
	assign shifted = whole16 >>> OUT_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			base_q      <= BASE_RESET;
			gain_q      <= '0;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			fb_q        <= '0;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (dsph_reg_t'(cfg_index))
					REG_ENABLE:        enable_q <= cfg_data[0];
					REG_BASE_DELAY:    base_q   <= cfg_data[BASE_W-1:0];
					REG_FEEDBACK_GAIN: gain_q   <= cfg_data[GAIN_W-1:0];
					default: begin
					end
				endcase
			end
			go_q <= start;
			if (fin) begin
				fb_q      <= fb_sat;
				wp_q      <= wp_q + ADDR_W'(1);
				wrapped_q <= wrapped_q || (&wp_q);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample_in;
			wet0_q <= wet0;
			res_q  <= sample_in;
		end
		if (chain_done) begin
			wetf_q <= link[STAGE_COUNT].wet;
		end
		if (state_q == ST_MULT) begin
			prod_q <= wetf_q * gain_q;
		end
		if (fin) begin
			res_q <= shifted;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule

### rtl/dsph_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsph_checker import dsph_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    cfg_we,
	input logic [CFG_IDX_W-1:0]    cfg_index,
	input logic [CFG_W-1:0]        cfg_data,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic signed [SMP_W-1:0] sample_in,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [SMP_W-1:0] sample_out
);

	logic [1:0] pend_q;
	logic       en_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			en_q   <= 1'b0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
			if (cfg_we && (cfg_index == REG_ENABLE)) begin
				en_q <= cfg_data[0];
			end
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample_out), "result word changed or dropped while stalled")
	`ASSERT_IMPL(a_no_invented, clk, arst_n, out_valid, pend_q != 2'd0, "result word without an accepted input word")
	`ASSERT_IMPL(a_pend_bound, clk, arst_n, 1'b1, pend_q <= 2'd2, "more than two words held inside the block")
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_acc, !in_ready, "input taken again while a word is in flight")
	`ASSERT_NEXT(a_bypass, clk, arst_n, in_acc && !en_q && !out_valid, ##1 (out_valid && sample_out == $past(sample_in, 2)), "bypassed word not passed through unchanged")

endmodule

bind delay_stage_phaser dsph_checker u_dsph_checker (.*);

### tb/delay_stage_phaser_test.sv
`timescale 1ns / 1ps

module delay_stage_phaser_test;
	import dsph_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int RANDOM_PHASES   = 10;
	localparam int WORDS_PER_PHASE = 113;
	localparam int DRAIN_CYCLES    = 20;
	localparam int HOLD_AT_WORD    = 300;
	localparam int HOLD_CYCLES     = 400;
	localparam int STEADY_FROM     = 700;
	localparam int STEADY_TO       = 900;
	localparam int DIR_ROWS        = 33;

	typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		dsph_reg_t                idx;
		logic [CFG_W-1:0]         data;
		logic signed [SMP_W-1:0]  smp;
		logic                     known;
		logic signed [SMP_W-1:0]  want;
	} dir_row_t;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh7FFF, 1'b1, 16'sh7FFF},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh8000, 1'b1, 16'sh8000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh0000, 1'b1, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'shFFFF, 1'b1, 16'shFFFF},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh5555, 1'b1, 16'sh5555},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'shAAAA, 1'b1, 16'shAAAA},
		'{ROW_REG,  REG_ENABLE,        16'h0001, 16'sh0000, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh7FFF, 1'b1, 16'sh07FF},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh8000, 1'b1, 16'shF800},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh0000, 1'b1, 16'sh0000},
		'{ROW_REG,  REG_BASE_DELAY,    16'h0000, 16'sh0000, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh03E8, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'shFC18, 1'b0, 16'sh0000},
		'{ROW_REG,  REG_BASE_DELAY,    16'h0001, 16'sh0000, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh3039, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'shFFF9, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh7FFF, 1'b0, 16'sh0000},
		'{ROW_REG,  REG_FEEDBACK_GAIN, 16'h7FFF, 16'sh0000, 1'b0, 16'sh0000},
		'{ROW_REG,  REG_BASE_DELAY,    16'd409,  16'sh0000, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh7FFF, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh7FFF, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh7FFF, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh8000, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh8000, 1'b0, 16'sh0000},
		'{ROW_REG,  REG_FEEDBACK_GAIN, 16'h8000, 16'sh0000, 1'b0, 16'sh0000},
		'{ROW_REG,  REG_BASE_DELAY,    16'd511,  16'sh0000, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh8000, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh7FFF, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh0001, 1'b0, 16'sh0000},
		'{ROW_REG,  REG_ENABLE,        16'h0000, 16'sh0000, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh1234, 1'b1, 16'sh1234},
		'{ROW_REG,  REG_ENABLE,        16'h0001, 16'sh0000, 1'b0, 16'sh0000},
		'{ROW_WORD, REG_ENABLE,        16'h0000, 16'sh0064, 1'b0, 16'sh0000}
	};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [SMP_W-1:0] sample_in = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [SMP_W-1:0] sample_out;

	logic                    cfg_enable = 1'b0;
	logic [BASE_W-1:0]       cfg_base = BASE_RESET;
	logic signed [GAIN_W-1:0] cfg_gain = '0;
	dsph_acc_t               ring_mem [STAGE_COUNT][DELAY_DEPTH];
	logic [ADDR_W-1:0]       ring_wp = '0;
	dsph_acc_t               fb_acc = '0;

	logic signed [SMP_W-1:0] expected_out_q [$];
	logic signed [SMP_W-1:0] got_want;
	int                      sent_cnt = 0;
	int                      got_cnt = 0;
	int                      err_cnt = 0;
	int                      cycle_cnt = 0;
	int                      pending_gap = 0;
	int                      hold_left = 0;
	bit                      hold_done = 1'b0;

	delay_stage_phaser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	always #5 clk = ~clk;

	function automatic dsph_acc_t clamp_q24(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[ACC_W-1:0];
	endfunction

	function automatic logic signed [SMP_W-1:0] phaser_predict(input logic signed [SMP_W-1:0] x);
		longint    dry;
		dsph_acc_t wet;
		dsph_acc_t tap;
		dsph_acc_t cell_out;
		dsph_acc_t mix;
		int        dly;
		int        rd;
		int        whole;
		if (!cfg_enable) begin
			return x;
		end
		dry = longint'(x) * 256;
		wet = clamp_q24(longint'(fb_acc) + dry);
		for (int k = 0; k < STAGE_COUNT; k++) begin
			dly = (int'(cfg_base) + k * int'(cfg_base >> 1)) % DELAY_DEPTH;
			rd = (int'(ring_wp) + DELAY_DEPTH - dly) % DELAY_DEPTH;
			tap = ring_mem[k][rd];
			cell_out = clamp_q24(longint'(tap) - longint'(wet));
			ring_mem[k][ring_wp] = clamp_q24(longint'(wet) + longint'(tap));
			wet = cell_out;
		end
		ring_wp = ring_wp + 1'b1;
		fb_acc = clamp_q24((longint'(wet) * longint'(cfg_gain)) / 64'sd16384);
		mix = clamp_q24(dry + longint'(wet));
		whole = int'(mix) / 256;
		if (whole > 32767) begin
			whole = 32767;
		end
		if (whole < -32768) begin
			whole = -32768;
		end
		return SMP_W'(whole >>> OUT_SHIFT);
	endfunction

	function automatic int draw_gap(input int n);
		int g;
		g = 0;
		if (n >= STEADY_FROM && n < STEADY_TO) begin
			return 0;
		end
		while ($urandom_range(99) < 25) begin
			g++;
		end
		return g;
	endfunction

	function automatic logic signed [SMP_W-1:0] pick_sample();
		case ($urandom_range(19))
			0, 1: begin
				return 16'sh7FFF;
			end
			2: begin
				return 16'sh8000;
			end
			3, 4, 5, 6, 7: begin
				return SMP_W'($signed($urandom_range(512)) - 256);
			end
			default: begin
				return SMP_W'($urandom);
			end
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_base();
		case ($urandom_range(6))
			0: begin
				return 16'd0;
			end
			1: begin
				return 16'd1;
			end
			2: begin
				return 16'd409;
			end
			3: begin
				return 16'd511;
			end
			4, 5: begin
				return CFG_W'($urandom_range(409, 1));
			end
			default: begin
				return CFG_W'($urandom_range(511));
			end
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_gain();
		case ($urandom_range(5))
			0: begin
				return 16'h7FFF;
			end
			1: begin
				return 16'h8000;
			end
			2: begin
				return 16'h0000;
			end
			default: begin
				return CFG_W'($urandom);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		err_cnt++;
		$display("mismatch: %s", msg);
	endtask

	task automatic write_reg(input dsph_reg_t idx, input logic [CFG_W-1:0] val);
		in_valid = 1'b0;
		while (expected_out_q.size() != 0) begin
			@(negedge clk);
		end
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_ENABLE: begin
				cfg_enable = val[0];
			end
			REG_BASE_DELAY: begin
				cfg_base = val[BASE_W-1:0];
			end
			REG_FEEDBACK_GAIN: begin
				cfg_gain = val;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_word(input logic signed [SMP_W-1:0] x, input logic known,
			input logic signed [SMP_W-1:0] want);
		logic signed [SMP_W-1:0] pred;
		repeat (pending_gap) @(negedge clk);
		in_valid = 1'b1;
		sample_in = x;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		pred = phaser_predict(x);
		expected_out_q.push_back(known ? want : pred);
		sent_cnt++;
		pending_gap = draw_gap(sent_cnt);
		if (pending_gap != 0) begin
			in_valid = 1'b0;
		end
	endtask

	// The receiver stalls at random, holds off once for a long stretch so the
	// block backs up into its input, and keeps ready high through a steady window.
	always @(negedge clk) begin
		if (!hold_done && got_cnt >= HOLD_AT_WORD) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else if (got_cnt >= STEADY_FROM && got_cnt < STEADY_TO) begin
			out_ready = 1'b1;
		end else begin
			out_ready = ($urandom_range(99) >= 25);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_out_q.size() == 0) begin
				report_mismatch($sformatf("word %0d: sample_out %0d with nothing expected",
					got_cnt, sample_out));
			end else begin
				got_want = expected_out_q.pop_front();
				if (sample_out !== got_want) begin
					report_mismatch($sformatf("word %0d: sample_out %0d, expected %0d",
						got_cnt, sample_out, got_want));
				end
			end
			got_cnt++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < STAGE_COUNT; k++) begin
			for (int a = 0; a < DELAY_DEPTH; a++) begin
				ring_mem[k][a] = '0;
			end
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_REG) begin
				write_reg(dir_rows[r].idx, dir_rows[r].data);
			end else begin
				send_word(dir_rows[r].smp, dir_rows[r].known, dir_rows[r].want);
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(REG_ENABLE, {15'($urandom), ($urandom_range(99) < 85) ? 1'b1 : 1'b0});
			write_reg(REG_BASE_DELAY, pick_base());
			write_reg(REG_FEEDBACK_GAIN, pick_gain());
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				send_word(pick_sample(), 1'b0, '0);
			end
		end

		in_valid = 1'b0;
		while (expected_out_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
